// ===== rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search: command and
// status codes, beat formats on both sides, and the internal work format.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Store geometry
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  // Fixed field widths of the beats
  localparam int CMD_W   = 3;
  localparam int FIELD_W = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // Command codes on the input beat
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_SEARCH
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEARCH
  } bk_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [FIELD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [POS_W-1:0]          match_position;
    logic signed [FIELD_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;
  } result_t;

  typedef struct packed {
    op_t                    op;
    logic [VALUE_WIDTH-1:0] value;
  } work_t;

endpackage

// ===== rtl/bdq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_front
// Accepts input beats, decodes the command and fits the value to the store
// width, and holds the decoded work in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bdq_front
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     work_valid,
  input  logic     work_take,
  output work_t    work
);

  work_t       slots [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  qcount;
  logic [1:0]  qcount_next;
  logic        wr;
  logic        rd;
  work_t       decoded;
  logic [63:0] value_wide;

  // Decode the command and sign-extend, then trim the value
  always_comb begin
    value_wide    = {{32{item.value[FIELD_W-1]}}, item.value};
    decoded.value = value_wide[VALUE_WIDTH-1:0];
    unique case (item.command)
      CMD_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
      CMD_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
      CMD_POP_BACK:   decoded.op = OP_POP_BACK;
      CMD_POP_FRONT:  decoded.op = OP_POP_FRONT;
      CMD_SEARCH:     decoded.op = OP_SEARCH;
      default:        decoded.op = OP_NOP;
    endcase
  end

  assign full       = (qcount == 2'd2);
  assign work_valid = (qcount != 2'd0);
  assign work       = slots[rd_ptr];
  assign wr         = push && !full;
  assign rd         = work_valid && work_take;

  always_comb begin
    qcount_next = qcount + {1'b0, wr} - {1'b0, rd};
  end

  // Advance queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      qcount <= qcount_next;
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Capture the decoded beat
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= decoded;
    end
  end

endmodule

// ===== rtl/bdq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_back
// Executes decoded work on the circular store. Pushes and pops finish as
// they are taken; a search registers the row of per-slot compares, then rotates
// it to front order and picks the first hit in the cycle after.
// ----------------------------------------------------------------------------
module bdq_back
  import bdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    work_valid,
  output logic    work_take,
  input  work_t   work,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [IDX_W-1:0]       front_idx;
  logic [IDX_W-1:0]       front_idx_next;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  bk_state_t              state;
  bk_state_t              state_next;
  logic [DEPTH-1:0]       hit_vec;
  logic [DEPTH-1:0]       hit_now;
  logic                   hit_load;
  logic [DEPTH-1:0]       rot;
  logic                   found;
  logic [IDX_W-1:0]       first;
  logic [31:0]            first_wide;
  logic [31:0]            count_wide;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [IDX_W-1:0]       rd_addr;
  logic [63:0]            rd_wide;
  logic [IDX_W-1:0]       back_slot;
  logic [IDX_W-1:0]       last_slot;
  logic [IDX_W-1:0]       front_dec;
  logic [IDX_W-1:0]       front_inc;

  // Physical slot of a position counted from the front
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(pos);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign back_slot = slot_of(front_idx, count);
  assign last_slot = slot_of(front_idx, count - CNT_W'(1));
  assign front_inc = slot_of(front_idx, CNT_W'(1));
  assign front_dec = (front_idx == '0) ? IDX_W'(DEPTH - 1) : front_idx - IDX_W'(1);
  assign rd_wide   = 64'(mem[rd_addr]);

  // Compare every occupied slot against the searched value
  always_comb begin
    logic [SUM_W-1:0] pos;
    for (int j = 0; j < DEPTH; j++) begin
      if (SUM_W'(j) >= SUM_W'(front_idx)) begin
        pos = SUM_W'(j) - SUM_W'(front_idx);
      end else begin
        pos = SUM_W'(j) + SUM_W'(DEPTH) - SUM_W'(front_idx);
      end
      hit_now[j] = (mem[j] == work.value) && (pos < SUM_W'(count));
    end
  end

  // Rotate the registered hits to front order and pick the first
  always_comb begin
    for (int p = 0; p < DEPTH; p++) begin
      rot[p] = hit_vec[slot_of(front_idx, CNT_W'(p))];
    end
    found = 1'b0;
    first = '0;
    for (int p = DEPTH - 1; p >= 0; p--) begin
      if (rot[p]) begin
        found = 1'b1;
        first = IDX_W'(p);
      end
    end
    first_wide = 32'(first);
  end

  // Sequence the work and build the result beat
  always_comb begin
    state_next     = state;
    work_take      = 1'b0;
    res_push       = 1'b0;
    hit_load       = 1'b0;
    front_idx_next = front_idx;
    count_next     = count;
    wr_en          = 1'b0;
    wr_addr        = front_idx;
    rd_addr        = front_idx;
    res            = '0;
    res.status     = ST_OK;
    unique case (state)
      BK_IDLE: begin
        if (work_valid && !res_full) begin
          work_take = 1'b1;
          res_push  = 1'b1;
          unique case (work.op)
            OP_PUSH_BACK: begin
              if (count == CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = back_slot;
                count_next = count + CNT_W'(1);
              end
            end
            OP_PUSH_FRONT: begin
              if (count == CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = front_dec;
                front_idx_next = front_dec;
                count_next     = count + CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                rd_addr           = last_slot;
                res.removed_value = rd_wide[FIELD_W-1:0];
                count_next        = count - CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                rd_addr           = front_idx;
                res.removed_value = rd_wide[FIELD_W-1:0];
                front_idx_next    = front_inc;
                count_next        = count - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              res_push   = 1'b0;
              hit_load   = 1'b1;
              state_next = BK_SEARCH;
            end
            OP_NOP: begin
              res.status = ST_OK;
            end
            default: begin
              res.status = ST_OK;
            end
          endcase
        end
      end
      BK_SEARCH: begin
        res_push   = 1'b1;
        state_next = BK_IDLE;
        if (found) begin
          res.status         = ST_OK;
          res.match_position = first_wide[POS_W-1:0];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    count_wide      = 32'(count_next);
    res.entry_count = count_wide[COUNT_W-1:0];
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      front_idx <= '0;
      count     <= '0;
    end else begin
      state     <= state_next;
      front_idx <= front_idx_next;
      count     <= count_next;
    end
  end

  // Store writes and the registered compare row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= work.value;
    end
    if (hit_load) begin
      hit_vec <= hit_now;
    end
  end

endmodule

// ===== rtl/bdq_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_out
// Two-entry result queue; parts the back end from the consumer so results
// can wait while new work is taken.
// ----------------------------------------------------------------------------
module bdq_out
  import bdq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  result_t    slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] qcount;
  logic [1:0] qcount_next;
  logic       wr;
  logic       rd;

  assign res_full = (qcount == 2'd2);
  assign empty    = (qcount == 2'd0);
  assign result   = slots[rd_ptr];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_comb begin
    qcount_next = qcount + {1'b0, wr} - {1'b0, rd};
  end

  // Advance queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      qcount <= qcount_next;
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= res;
    end
  end

endmodule

// ===== rtl/bounded_deque_with_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_unit
// Double-ended queue of signed values with push/pop at both ends and a
// search that reports the front-relative position of the first match.
// ----------------------------------------------------------------------------
// Both sides behave as queues: write a command beat with push while full is
// low, and read one result beat per command with pop while empty is low. The
// execution unit finishes pushes, pops and unused codes as it takes them, and
// a search in two steps (a registered row of per-slot compares, then a rotate
// and first-hit pick), so the sustained rate is one command per cycle while
// the result queue has room; a search holds off the next command until its
// result issues. A result reaches the result ports through both queues, a
// search also through the compare row. Two-entry queues on the input and
// result sides let each side stall independently. Store contents need no
// clearing after reset; the block takes commands as soon as reset is low.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_unit
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic    work_valid;
  logic    work_take;
  work_t   work;
  logic    res_full;
  logic    res_push;
  result_t res;

  bdq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .work_valid (work_valid),
    .work_take  (work_take),
    .work       (work)
  );

  bdq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work_take  (work_take),
    .work       (work),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  bdq_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

`ifndef ASSERT_OFF
  // The back end never issues a result into a full result queue
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result issued into full result queue");

  // A rejected push reports a full store
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_FULL) |-> result.entry_count == COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  // A pop from an empty store reports no entries and no value
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_EMPTY) |->
      (result.entry_count == '0 && result.removed_value == '0))
    else $error("empty status with entries or a removed value");

  // Work is only taken from a nonempty front queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    work_take |-> work_valid)
    else $error("work taken from empty front queue");
`endif

endmodule
